[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the bandwidth limiter.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication check, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hw/rtl/pbl_pkg.sv]
// Package for the priority bandwidth limiter: operation codes, constants, widths.
// Depends on nothing; used by pbl_core and priority_bandwidth_limiter.
package pbl_pkg;
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_CHECK = 2'd1;
   localparam logic [1:0] OP_ACK   = 2'd2;
   localparam logic [1:0] OP_RETRY = 2'd3;

   localparam int LIMIT_W = 24;
   localparam int SLICE_MS = 125;
   localparam int PERCENT = 100;
   localparam int SLICES_PER_SEC = 8;
   localparam int PCT_W = 7;
   localparam int PCT_TABLE_W = 35;
   localparam int PACKET_SHIFT = 9;

   localparam logic [2:0] REG_LMIN  = 3'd0;
   localparam logic [2:0] REG_LMAX  = 3'd1;
   localparam logic [2:0] REG_CBUF  = 3'd2;
   localparam logic [2:0] REG_SCALE = 3'd3;
   localparam logic [2:0] REG_UHF   = 3'd4;
   localparam logic [2:0] REG_PCT   = 3'd5;

   typedef struct packed {
      logic [23:0] lmin;
      logic [23:0] lmax;
      logic [7:0]  cbuf;
      logic [15:0] scale;
      logic        uhf;
      logic [34:0] pct;
   } cfg_type;
endpackage

[hw/rtl/priority_bandwidth_limiter.sv]
// Top level of the priority bandwidth limiter: APB-style registers, handshake, result register.
// Depends on pbl_pkg, pbl_core and assert_macros.svh.
//
// The block takes one event item at a time (tick, send check, ack or retry) and
// returns exactly one result item for it. The only variable divide (the ack growth)
// runs through a restoring divider in pbl_core that retires one quotient bit a cycle
// over 48 bits; the same registers serve as a square-root unit retiring one root bit
// (two radicand bits) a cycle for the retry. The divides by 125 and by 100 are done
// in the state S_RDIV by reciprocal multiplication. From the accepting edge to the
// edge that loads the result, an ack runs 48 divide steps, the clip and the finish; a
// retry runs the radicand, 24 root steps, the clip and the finish; a tick runs, when
// slices have passed, the slice count, then share, divide and drain for each of the
// five priorities, then the finish, and only the finish when none has; and a send
// check runs a cap, a divide and an update for each priority visited, then a commit
// for an admitted packet and the finish. req_ready is low while an item is in work
// and rises at the edge that loads its result. The result sits in an output register,
// so the next item is taken while it waits; a finished item whose result finds that
// register still full holds in the core until the register drains. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
// A new limit minimum takes effect at the next ack or retry.
`include "assert_macros.svh"
module priority_bandwidth_limiter #(
   parameter int NUM_PRIORITIES = 5,
   parameter int COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_byte_count,
   input  logic [2:0]  req_priority_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [23:0] rsp_current_limit,
   output logic [7:0]  rsp_buffer_packets,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   pbl_pkg::cfg_type cfg_ff, cfg_in;
   logic busy_ff, busy_in;
   logic rv_ff, rv_in;
   logic acc_ff;
   logic [23:0] lim_ff;
   logic [7:0] bp_ff, bp_in;
   logic start, done, core_acc;
   logic out_free;
   logic [23:0] core_lim;
   logic [2:0] ridx;
   logic [14:0] pk;

   assign pready = 1'b1;
   assign ridx = paddr[5:3];
   // The output register can take a new result when empty or being drained.
   assign out_free = !rv_ff || rsp_ready;
   assign req_ready = !busy_ff;
   assign start = req_valid && req_ready;

   pbl_core #(.NUM_PRIORITIES(NUM_PRIORITIES), .COUNT_BITS(COUNT_BITS)) u_core (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .start(start), .out_free(out_free),
      .op(req_op), .now_ms(req_now_ms), .byte_count(req_byte_count),
      .priority_req(req_priority_req), .done(done), .accepted(core_acc),
      .limit(core_lim)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (ridx)
            pbl_pkg::REG_LMIN:  cfg_in.lmin = pwdata[23:0];
            pbl_pkg::REG_LMAX:  cfg_in.lmax = pwdata[23:0];
            pbl_pkg::REG_CBUF:  cfg_in.cbuf = pwdata[7:0];
            pbl_pkg::REG_SCALE: cfg_in.scale = pwdata[15:0];
            pbl_pkg::REG_UHF:   cfg_in.uhf = pwdata[0];
            pbl_pkg::REG_PCT:   cfg_in.pct = pwdata[34:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         pbl_pkg::REG_LMIN:  prdata = 64'(cfg_ff.lmin);
         pbl_pkg::REG_LMAX:  prdata = 64'(cfg_ff.lmax);
         pbl_pkg::REG_CBUF:  prdata = 64'(cfg_ff.cbuf);
         pbl_pkg::REG_SCALE: prdata = 64'(cfg_ff.scale);
         pbl_pkg::REG_UHF:   prdata = 64'(cfg_ff.uhf);
         pbl_pkg::REG_PCT:   prdata = 64'(cfg_ff.pct);
         default:            prdata = '0;
      endcase
   end

   // Packets the client can buffer: limit/512 clipped to 1..client_buffer_packets.
   assign pk = core_lim[23:pbl_pkg::PACKET_SHIFT];
   always_comb begin
      if (pk > 15'(cfg_ff.cbuf)) bp_in = cfg_ff.cbuf;
      else if (pk < 15'd1) bp_in = 8'd1;
      else bp_in = pk[7:0];
   end

   always_comb begin
      busy_in = busy_ff;
      rv_in = rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      if (start) busy_in = 1'b1;
      if (done) begin
         busy_in = 1'b0;
         rv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{lmin: 24'd2500, lmax: 24'd102400, cbuf: 8'd30, scale: 16'd512,
                     uhf: 1'b0, pct: 35'd1373967380};
         busy_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         busy_ff <= busy_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         acc_ff <= core_acc;
         lim_ff <= core_lim;
         bp_ff <= bp_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_current_limit = lim_ff;
   assign rsp_buffer_packets = bp_ff;

   `ASSERT_IMPL(a_no_start_busy, clock, reset, busy_ff, !start)
   `ASSERT_NEXT(a_done_valid, clock, reset, done, rsp_valid)
   `ASSERT_IMPL(a_done_busy, clock, reset, done, busy_ff)
endmodule

[hw/rtl/pbl_core.sv]
// Sequencer and shared divide/square-root unit of the priority bandwidth limiter.
// Depends on pbl_pkg.
module pbl_core #(
   parameter int NUM_PRIORITIES = 5,
   parameter int COUNT_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pbl_pkg::cfg_type       cfg,
   input  logic                   start,
   input  logic                   out_free,
   input  logic [1:0]             op,
   input  logic [31:0]            now_ms,
   input  logic [15:0]            byte_count,
   input  logic [2:0]             priority_req,
   output logic                   done,
   output logic                   accepted,
   output logic [23:0]            limit
);
   localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [5:0] ITER = 6'd48;
   localparam int RW = 34;
   // Reciprocals for the constant divides: exact for dividends below 2^31.
   localparam logic [31:0] RECIP_SLICE = 32'd2199023256;
   localparam logic [31:0] RECIP_PERCENT = 32'd2748779070;
   localparam int RECIP_SHIFT = 38;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TDIV = 4'd1;  // variable divide, one quotient bit a cycle
   localparam logic [3:0] S_TSH  = 4'd2;  // share = limit*pct, start /100
   localparam logic [3:0] S_TDIV2 = 4'd3;
   localparam logic [3:0] S_TDR  = 4'd4;  // drain = slices*share >> 3
   localparam logic [3:0] S_CCAP = 4'd5;
   localparam logic [3:0] S_CDIV = 4'd6;
   localparam logic [3:0] S_CUPD = 4'd7;
   localparam logic [3:0] S_ADIV = 4'd8;
   localparam logic [3:0] S_RSQ  = 4'd9;
   localparam logic [3:0] S_FIN  = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;
   localparam logic [3:0] S_COMMIT = 4'd12;
   localparam logic [3:0] S_RDIV = 4'd13;  // constant divide by reciprocal multiply

   logic [3:0]  state_ff, state_in;
   logic [31:0] start_ms_ff, start_ms_in;
   logic [23:0] limit_ff, limit_in;
   logic [COUNT_BITS-1:0] bkt_ff [NUM_PRIORITIES];
   logic [COUNT_BITS-1:0] bkt_in [NUM_PRIORITIES];
   logic [COUNT_BITS-1:0] work_ff [NUM_PRIORITIES];
   logic [COUNT_BITS-1:0] work_in [NUM_PRIORITIES];
   logic        hit_ff, hit_in;
   logic        acc_ff, acc_in;
   logic [PW-1:0] p_ff, p_in;
   logic [1:0]  op_ff, op_in;
   logic [16:0] need_ff, need_in;
   logic [31:0] slices_ff, slices_in;
   // Shared iterative unit: restoring divider and digit-pair square root.
   logic [47:0] num_ff, num_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [23:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [3:0]  back_ff, back_in;

   logic [6:0]  pct_p;
   logic [48:0] rem_sh;
   logic [49:0] sq_try;
   logic [47:0] prod;
   logic [24:0] sum25;
   logic [31:0] rmul;

   always_comb begin
      logic [34:0] sh;
      sh = cfg.pct >> (7 * 32'(p_ff));
      pct_p = (7 * (32'(p_ff) + 1) > 35) ? 7'd0 : sh[6:0];
   end

   assign rem_sh = {rem_ff, num_ff[47]};
   assign sq_try = {rem_ff, num_ff[47:46]} - {quo_ff, 2'b01};
   assign rmul   = (den_ff == 24'(pbl_pkg::SLICE_MS)) ? RECIP_SLICE : RECIP_PERCENT;

   always_comb begin
      logic [48:0] dv;
      logic signed [RW-1:0] room;
      logic [24:0] cap25;
      logic [RW-1:0] ws;
      logic [31:0] ds;
      logic [24:0] lsum;
      logic [63:0] rq;
      logic [56:0] dr;
      state_in = state_ff; start_ms_in = start_ms_ff; limit_in = limit_ff;
      bkt_in = bkt_ff; work_in = work_ff; hit_in = hit_ff; acc_in = acc_ff;
      p_in = p_ff; op_in = op_ff; need_in = need_ff; slices_in = slices_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; back_in = back_ff;
      prod = '0; sum25 = '0;
      dv = '0; room = '0; cap25 = '0; ws = '0; ds = '0; lsum = '0; rq = '0; dr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = op; acc_in = 1'b0;
               unique case (op)
                  pbl_pkg::OP_TICK: begin
                     ds = now_ms - start_ms_ff;
                     if (ds[31] || ds <= 32'(pbl_pkg::SLICE_MS)) begin
                        state_in = S_DONE;
                     end else begin
                        num_in = {16'd0, ds - 32'd1}; den_in = 24'(pbl_pkg::SLICE_MS);
                        p_in = '0;
                        back_in = S_TSH; state_in = S_RDIV;
                     end
                  end
                  pbl_pkg::OP_CHECK: begin
                     p_in = (32'(priority_req) >= NUM_PRIORITIES) ?
                        PW'(NUM_PRIORITIES - 1) : PW'(priority_req);
                     need_in = {1'b0, byte_count};
                     work_in = bkt_ff;
                     state_in = S_CCAP;
                  end
                  pbl_pkg::OP_ACK: begin
                     prod = 48'(cfg.scale) * 48'(cfg.scale);
                     num_in = (cfg.uhf && hit_ff) ? (prod << 2) : prod;
                     if (cfg.uhf && hit_ff) hit_in = 1'b0;
                     den_in = (limit_ff == '0) ? 24'd1 : limit_ff;
                     rem_in = '0; quo_in = '0; cnt_in = ITER;
                     back_in = S_FIN; state_in = S_TDIV;
                  end
                  default: begin
                     prod = 48'(limit_ff) * 48'(limit_ff);
                     num_in = '0;
                     state_in = S_RSQ; back_in = S_FIN;
                     rem_in = '0; quo_in = '0; cnt_in = 6'd24;
                     // Radicand prepared in the next cycle from num.
                     num_in = prod;
                     den_in = {8'd0, cfg.scale};
                     slices_in = 32'd1;
                  end
               endcase
            end
         end
         S_TDIV: begin
            dv = rem_sh - {25'd0, den_ff};
            if (!dv[48]) begin
               rem_in = dv[47:0]; quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = rem_sh[47:0]; quo_in = {quo_ff[46:0], 1'b0};
            end
            num_in = {num_ff[46:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = back_ff;
         end
         S_RDIV: begin
            rq = 64'(num_ff[30:0]) * 64'(rmul);
            quo_in = 48'(rq >> RECIP_SHIFT);
            state_in = back_ff;
         end
         S_TSH: begin
            if (op_ff == pbl_pkg::OP_TICK && back_ff == S_TSH) begin
               slices_in = quo_ff[31:0];
               start_ms_in = start_ms_ff + 32'(quo_ff[31:0] * 32'(pbl_pkg::SLICE_MS));
               p_in = '0;
            end
            prod = 48'(limit_ff) * 48'(pct_p);
            num_in = prod; den_in = 24'(pbl_pkg::PERCENT);
            back_in = S_TDR; state_in = S_RDIV;
         end
         S_TDR: begin
            dr = (57'(slices_ff) * 57'(quo_ff[24:0])) >> 3;
            bkt_in[p_ff] = (57'(bkt_ff[p_ff]) > dr) ?
               COUNT_BITS'(57'(bkt_ff[p_ff]) - dr) : '0;
            if (32'(p_ff) == NUM_PRIORITIES - 1) begin
               state_in = S_DONE;
            end else begin
               p_in = p_ff + PW'(1); back_in = S_TDIV2; state_in = S_TSH;
            end
         end
         S_CCAP: begin
            prod = 48'(limit_ff) * 48'(pct_p);
            num_in = prod; den_in = 24'(pbl_pkg::PERCENT);
            back_in = S_CUPD; state_in = S_RDIV;
         end
         S_CUPD: begin
            cap25 = quo_ff[24:0];
            room = $signed(RW'(cap25)) - $signed(RW'(work_ff[p_ff]));
            if (room >= $signed(RW'(need_ff))) begin
               ws = RW'(work_ff[p_ff]) + RW'(need_ff);
               work_in[p_ff] = (ws > RW'(CMAX)) ? CMAX : COUNT_BITS'(ws);
               state_in = S_COMMIT;
            end else begin
               if (room > 0) begin
                  ws = RW'(work_ff[p_ff]) + unsigned'(room);
                  work_in[p_ff] = (ws > RW'(CMAX)) ? CMAX : COUNT_BITS'(ws);
                  need_in = need_ff - 17'(room);
               end
               if (p_ff == '0) begin
                  hit_in = 1'b1; state_in = S_DONE;
               end else begin
                  p_in = p_ff - PW'(1); state_in = S_CCAP;
               end
            end
         end
         S_COMMIT: begin
            bkt_in = work_ff; acc_in = 1'b1; state_in = S_DONE;
         end
         S_RSQ: begin
            if (slices_ff == 32'd1) begin
               // Radicand = limit^2 - 4*scale^2, clamped at zero.
               prod = 48'(den_ff) * 48'(den_ff);
               prod = prod << 2;
               num_in = (num_ff > prod) ? num_ff - prod : '0;
               slices_in = 32'd0;
            end else begin
               if (!sq_try[49]) begin
                  rem_in = sq_try[47:0]; quo_in = {quo_ff[46:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[45:0], num_ff[47:46]}; quo_in = {quo_ff[46:0], 1'b0};
               end
               num_in = {num_ff[45:0], 2'b00};
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (op_ff == pbl_pkg::OP_ACK) begin
               prod = 48'(limit_ff) + quo_ff;
               if (prod > 48'(cfg.lmax)) limit_in = cfg.lmax;
               else if (prod < 48'(cfg.lmin)) limit_in = cfg.lmin;
               else limit_in = prod[23:0];
            end else begin
               sum25 = 25'(limit_ff) + 25'(quo_ff[23:0]);
               lsum = sum25 >> 1;
               if (lsum > 25'(cfg.lmax)) limit_in = cfg.lmax;
               else if (lsum < 25'(cfg.lmin)) limit_in = cfg.lmin;
               else limit_in = lsum[23:0];
            end
            state_in = S_DONE;
         end
         S_TDIV2: state_in = S_TSH;
         // The finished result waits here until the output register is free.
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ms_ff <= '0;
         limit_ff <= 24'd2500;
         hit_ff <= 1'b0;
         for (int i = 0; i < NUM_PRIORITIES; i++) bkt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         start_ms_ff <= start_ms_in;
         limit_ff <= limit_in;
         hit_ff <= hit_in;
         bkt_ff <= bkt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in; acc_ff <= acc_in; p_ff <= p_in; op_ff <= op_in;
      need_ff <= need_in; slices_ff <= slices_in; num_ff <= num_in;
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; cnt_ff <= cnt_in;
      back_ff <= back_in;
   end

   assign done = (state_ff == S_DONE) && out_free;
   assign accepted = acc_ff;
   assign limit = limit_ff;
endmodule

[bench/tb_top.sv]
// Self-checking testbench for the priority bandwidth limiter.
// Depends on pbl_pkg and the priority_bandwidth_limiter RTL; nothing else.
module tb_top;
   localparam int NPRI = 5;
   localparam int CNT_W = 24;
   localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 3000;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] now_ms;
      logic [15:0] bytes;
      logic [2:0]  pri;
   } event_item_type;

   typedef struct {
      logic        accepted;
      logic [23:0] limit;
      logic [7:0]  buf_pkts;
   } limit_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = pbl_pkg::OP_TICK;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_byte_count = '0;
   logic [2:0]  req_priority_req = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accepted;
   logic [23:0] rsp_current_limit;
   logic [7:0]  rsp_buffer_packets;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [5:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   priority_bandwidth_limiter dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the configuration and state of the limiter.
   longint unsigned m_lmin, m_lmax, m_cbuf, m_scale, m_uhf, m_pct;
   longint unsigned m_limit;
   longint unsigned m_bucket [NPRI];
   logic [31:0]     m_slice_start;
   bit              m_hit;

   event_item_type   pending_items[$];
   limit_result_type expected_results[$];
   int          errors = 0;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_cnt = 0;
   int          stall_cnt = 0;
   int          gap_cnt = 0;
   bit          in_acc = 1'b0;
   longint      cycles = 0;
   logic [31:0] clock_ms = '0;

   function automatic longint unsigned clip(longint unsigned x, longint unsigned lo,
                                            longint unsigned hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic longint unsigned pct_share(int p);
      if (7 * p + 7 > 35) return 0;
      return (m_pct >> (7 * p)) & 64'h7f;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Applies one event to the shadow state and returns the result it must produce.
   function automatic limit_result_type predict_limit(event_item_type it);
      limit_result_type r;
      longint unsigned work [NPRI];
      longint unsigned sq, dv, slices, share, drain, rad;
      longint need, cap, room;
      logic [31:0] diff;
      int p;
      r.accepted = 1'b0;
      case (it.op)
         pbl_pkg::OP_TICK: begin
            diff = it.now_ms - m_slice_start;
            if (!(diff > 32'h7fffffff || diff <= pbl_pkg::SLICE_MS)) begin
               slices = (diff - 1) / pbl_pkg::SLICE_MS;
               m_slice_start += 32'(slices * pbl_pkg::SLICE_MS);
               for (int i = 0; i < NPRI; i++) begin
                  share = m_limit * pct_share(i) / pbl_pkg::PERCENT;
                  drain = slices * share / pbl_pkg::SLICES_PER_SEC;
                  m_bucket[i] = (m_bucket[i] > drain) ? m_bucket[i] - drain : 0;
               end
            end
         end
         pbl_pkg::OP_CHECK: begin
            need = it.bytes;
            p = (it.pri >= NPRI) ? NPRI - 1 : int'(it.pri);
            work = m_bucket;
            for (; p >= 0; p--) begin
               cap = pct_share(p) * m_limit / pbl_pkg::PERCENT;
               room = cap - longint'(work[p]);
               if (room >= need) begin
                  work[p] = work[p] + need;
                  if (work[p] > CNT_MAX) work[p] = CNT_MAX;
                  m_bucket = work;
                  r.accepted = 1'b1;
                  break;
               end else if (room > 0) begin
                  work[p] = work[p] + room;
                  if (work[p] > CNT_MAX) work[p] = CNT_MAX;
                  need -= room;
               end
            end
            if (!r.accepted) m_hit = 1'b1;
         end
         pbl_pkg::OP_ACK: begin
            sq = m_scale * m_scale;
            dv = (m_limit == 0) ? 1 : m_limit;
            if (m_uhf != 0 && m_hit) begin
               m_limit += 4 * sq / dv;
               m_hit = 1'b0;
            end else begin
               m_limit += sq / dv;
            end
            m_limit = clip(m_limit, m_lmin, m_lmax);
         end
         default: begin
            sq = m_limit * m_limit;
            rad = 4 * m_scale * m_scale;
            rad = (sq > rad) ? sq - rad : 0;
            m_limit = (m_limit + int_sqrt(rad)) / 2;
            m_limit = clip(m_limit, m_lmin, m_lmax);
         end
      endcase
      r.limit = m_limit[23:0];
      r.buf_pkts = 8'(clip(m_limit / 512, 1, m_cbuf));
      return r;
   endfunction

   // Sampled handshake flag so the driver sees the edge value, not later updates.
   always @(posedge clock) begin
      in_acc <= req_valid && req_ready;
      cycles <= cycles + 1;
   end

   // Driver: offers queued items with random gaps; the prediction is made on acceptance.
   always @(negedge clock) begin
      if (!reset) begin
         if (in_acc) begin
            expected_results.push_back(predict_limit(pending_items.pop_front()));
         end
         if (in_acc || !req_valid) begin
            if (gap_cnt > 0) begin
               gap_cnt <= gap_cnt - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_op <= pending_items[0].op;
               req_now_ms <= pending_items[0].now_ms;
               req_byte_count <= pending_items[0].bytes;
               req_priority_req <= pending_items[0].pri;
               gap_cnt <= ($urandom_range(0, 29) == 0) ? int'($urandom_range(20, 150)) :
                          int'($urandom_range(0, 2));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stalls at random, mostly briefly and now and then for long, and holds
   // off for a long counted stretch when asked to.
   always @(negedge clock) begin
      if (hold_req && !hold_done) begin
         rsp_ready <= 1'b0;
         if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
         else hold_cnt <= hold_cnt + 1;
      end else if (stall_cnt > 0) begin
         rsp_ready <= 1'b0;
         stall_cnt <= stall_cnt - 1;
      end else if ($urandom_range(0, 99) == 0) begin
         rsp_ready <= 1'b0;
         stall_cnt <= int'($urandom_range(20, 150));
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Monitor: every accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      limit_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_accepted !== e.accepted) begin
               $error("accepted: expected %0d, got %0d", e.accepted, rsp_accepted);
               errors++;
            end
            if (rsp_current_limit !== e.limit) begin
               $error("current_limit: expected %0d, got %0d", e.limit, rsp_current_limit);
               errors++;
            end
            if (rsp_buffer_packets !== e.buf_pkts) begin
               $error("buffer_packets: expected %0d, got %0d", e.buf_pkts,
                      rsp_buffer_packets);
               errors++;
            end
         end
      end
   end

   // The driver pops at the negedge after acceptance, so an item counts as taken when
   // it leaves the queue; the monitor may see its result only after that.
   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, longint unsigned val);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 3'b000}; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         pbl_pkg::REG_LMIN:  m_lmin = val & 24'hffffff;
         pbl_pkg::REG_LMAX:  m_lmax = val & 24'hffffff;
         pbl_pkg::REG_CBUF:  m_cbuf = val & 8'hff;
         pbl_pkg::REG_SCALE: m_scale = val & 16'hffff;
         pbl_pkg::REG_UHF:   m_uhf = val & 1;
         default:            m_pct = val & ((64'd1 << 35) - 1);
      endcase
   endtask

   task automatic push_item(logic [1:0] op, logic [31:0] now, logic [15:0] nbytes,
                            logic [2:0] pri);
      event_item_type it;
      it.op = op; it.now_ms = now; it.bytes = nbytes; it.pri = pri;
      pending_items.push_back(it);
   endtask

   // Random traffic: time mostly moves forward by sane steps, checks dominate, and
   // a sprinkling of time jumps backward or far ahead exercises the signed compare.
   task automatic random_phase(int n, int max_bytes);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 20) begin
            case ($urandom_range(0, 9))
               0: clock_ms = $urandom;
               1: clock_ms -= $urandom_range(0, 5000);
               default: clock_ms += $urandom_range(0, 700);
            endcase
            push_item(pbl_pkg::OP_TICK, clock_ms, 16'($urandom), 3'($urandom));
         end else if (sel < 75) begin
            push_item(pbl_pkg::OP_CHECK, $urandom,
                      ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, max_bytes)),
                      ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                      3'($urandom_range(0, 4)));
         end else if (sel < 90) begin
            push_item(pbl_pkg::OP_ACK, $urandom, 16'($urandom), 3'($urandom));
         end else begin
            push_item(pbl_pkg::OP_RETRY, $urandom, 16'($urandom), 3'($urandom));
         end
      end
   endtask

   initial begin
      m_lmin = 2500; m_lmax = 102400; m_cbuf = 30; m_scale = 512; m_uhf = 0;
      m_pct = 64'd1373967380;
      m_limit = 2500; m_slice_start = '0; m_hit = 1'b0;
      foreach (m_bucket[i]) m_bucket[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every operation, extreme fields, out-of-range priority, ticks too
      // soon and backward, a zero-byte check and oversized packets.
      push_item(pbl_pkg::OP_CHECK, 32'd0, 16'd0, 3'd0);
      push_item(pbl_pkg::OP_CHECK, 32'd0, 16'd400, 3'd4);
      push_item(pbl_pkg::OP_CHECK, 32'd0, 16'hffff, 3'd7);
      push_item(pbl_pkg::OP_CHECK, 32'd0, 16'd300, 3'd6);
      push_item(pbl_pkg::OP_TICK, 32'd125, 16'd0, 3'd0);
      push_item(pbl_pkg::OP_TICK, 32'd126, 16'd0, 3'd0);
      push_item(pbl_pkg::OP_TICK, 32'hffffffff, 16'd0, 3'd0);
      push_item(pbl_pkg::OP_TICK, 32'd2000, 16'hffff, 3'd7);
      push_item(pbl_pkg::OP_ACK, 32'd0, 16'd0, 3'd0);
      push_item(pbl_pkg::OP_RETRY, 32'd0, 16'd0, 3'd0);
      push_item(pbl_pkg::OP_ACK, 32'hffffffff, 16'hffff, 3'd7);
      push_item(pbl_pkg::OP_CHECK, 32'hffffffff, 16'd1, 3'd2);
      push_item(pbl_pkg::OP_RETRY, 32'hffffffff, 16'hffff, 3'd7);
      clock_ms = 32'd2000;
      wait_drained();

      // Hit flag on, scale at its top, wide bounds: fast growth after refusals.
      csr_write(pbl_pkg::REG_UHF, 64'd1);
      csr_write(pbl_pkg::REG_SCALE, 64'hffff);
      csr_write(pbl_pkg::REG_LMAX, 64'hffffff);
      csr_write(pbl_pkg::REG_CBUF, 64'hff);
      random_phase(400, 3000);
      wait_drained();

      // Receiver holds off for a long stretch so the block backs up its input.
      hold_req = 1'b1;
      random_phase(40, 3000);
      wait (hold_done);
      hold_req = 1'b0;
      wait_drained();

      // Crossed bounds, full percent table, minimal clips and zero scale.
      csr_write(pbl_pkg::REG_LMIN, 64'hffffff);
      csr_write(pbl_pkg::REG_LMAX, 64'd1);
      csr_write(pbl_pkg::REG_PCT, (64'd1 << 35) - 1);
      csr_write(pbl_pkg::REG_CBUF, 64'd1);
      csr_write(pbl_pkg::REG_SCALE, 64'd0);
      random_phase(200, 65535);
      wait_drained();

      // Zero bounds allow a zero limit; then small limits and a zero table.
      csr_write(pbl_pkg::REG_LMIN, 64'd0);
      csr_write(pbl_pkg::REG_LMAX, 64'd0);
      random_phase(60, 100);
      wait_drained();
      csr_write(pbl_pkg::REG_PCT, 64'd0);
      csr_write(pbl_pkg::REG_LMAX, 64'd600);
      csr_write(pbl_pkg::REG_SCALE, 64'd300);
      random_phase(150, 500);
      wait_drained();

      // Random settings for the bulk of the run.
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(pbl_pkg::REG_LMIN, 64'($urandom_range(1, 20000)));
         csr_write(pbl_pkg::REG_LMAX, ($urandom_range(0, 3) == 0) ? 64'(24'($urandom)) :
                   64'($urandom_range(20000, 300000)));
         csr_write(pbl_pkg::REG_CBUF, 64'($urandom_range(1, 255)));
         csr_write(pbl_pkg::REG_SCALE, 64'($urandom_range(0, 2000)));
         csr_write(pbl_pkg::REG_UHF, 64'($urandom_range(0, 1)));
         csr_write(pbl_pkg::REG_PCT, 64'({3'($urandom), 32'($urandom)}));
         random_phase(220, 4000);
         wait_drained();
      end
      csr_write(pbl_pkg::REG_LMIN, 64'd2500);
      csr_write(pbl_pkg::REG_LMAX, 64'd102400);
      csr_write(pbl_pkg::REG_PCT, 64'd1373967380);
      csr_write(pbl_pkg::REG_SCALE, 64'd512);
      random_phase(100, 2000);
      wait_drained();

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end
endmodule
